// ===== hdl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Types, sizes and operation codes shared by the key-value table modules.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int ENTRIES     = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int KEY_W       = 8;
    localparam int FUNC_W      = 2;
    localparam int WORD_W      = 32;
    localparam int ECOUNT_W    = 5;
    localparam int COUNT_W     = $clog2(ENTRIES + 1);

    localparam logic [FUNC_W-1:0] FN_GET    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] value_in;
    } in_t;

    typedef struct packed {
        logic                hit;
        logic [WORD_W-1:0]   value_out;
        logic                full_error;
        logic [ECOUNT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic                   we;
        logic [FUNC_W-1:0]      func;
        logic [KEY_W-1:0]       key;
        logic [VALUE_WIDTH-1:0] value;
        logic                   found_all;
        logic                   room;
    } cell_cmd_t;

    typedef struct packed {
        logic                   in_range;
        logic                   tail;
    } cell_pos_t;

    typedef struct packed {
        logic                   found;
        logic [VALUE_WIDTH-1:0] value;
    } cell_link_t;

endpackage

// ===== hdl/skvt_cell.sv =====
// ----------------------------------------------------------------------------
// skvt_cell
// One table slot: holds a key and a data word, compares the key, passes the
// search result up the chain and takes its upper neighbor's entry on remove.
// ----------------------------------------------------------------------------
module skvt_cell (
    input  logic                                aclk,
    input  skvt_pkg::cell_cmd_t                 cmd,
    input  skvt_pkg::cell_pos_t                 pos,
    input  skvt_pkg::cell_link_t                link_in,
    output skvt_pkg::cell_link_t                link_out,
    input  logic [skvt_pkg::KEY_W-1:0]          up_key,
    input  logic [skvt_pkg::VALUE_WIDTH-1:0]    up_data,
    output logic [skvt_pkg::KEY_W-1:0]          key_o,
    output logic [skvt_pkg::VALUE_WIDTH-1:0]    data_o
);

    logic [skvt_pkg::KEY_W-1:0]       key_reg;
    logic [skvt_pkg::KEY_W-1:0]       key_next;
    logic [skvt_pkg::VALUE_WIDTH-1:0] data_reg;
    logic [skvt_pkg::VALUE_WIDTH-1:0] data_next;
    logic                             match;
    logic                             first;

    assign match = pos.in_range && (key_reg == cmd.key);
    assign first = match && !link_in.found;

    assign link_out.found = link_in.found || match;
    assign link_out.value = link_in.value
                          | (first ? data_reg : '0);

    assign key_o  = key_reg;
    assign data_o = data_reg;

    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        if (cmd.we) begin
            unique case (cmd.func)
                skvt_pkg::FN_ADD: begin
                    if (first) begin
                        data_next = cmd.value;
                    end else if (!cmd.found_all && cmd.room && pos.tail) begin
                        key_next  = cmd.key;
                        data_next = cmd.value;
                    end
                end
                skvt_pkg::FN_REMOVE: begin
                    if (pos.in_range && link_out.found) begin
                        key_next  = up_key;
                        data_next = up_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

endmodule

// ===== hdl/small_key_value_table.sv =====
// ----------------------------------------------------------------------------
// small_key_value_table
// Key-value table with get, add-or-replace and remove operations.
// ----------------------------------------------------------------------------
// The table takes one transaction per cycle unless a held result is stalled by m_ready,
// and presents its result in the cycle after acceptance; the rate is set by a
// single pass of the key through the chain of slot cells, which all compare in
// parallel while the first match ripples along the chain. Remove closes the
// gap by shifting the entries above the removed slot down one cell, so slots
// keep insertion order; results do not depend on it since keys are unique. An
// add of a new key to a full table changes nothing and reports full_error.
module small_key_value_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  skvt_pkg::in_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output skvt_pkg::out_t      m_data
);

    localparam int N = skvt_pkg::ENTRIES;

    logic                             accept;
    logic [skvt_pkg::COUNT_W-1:0]     count_reg;
    logic [skvt_pkg::COUNT_W-1:0]     count_next;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    skvt_pkg::out_t                   m_data_reg;
    skvt_pkg::out_t                   m_data_next;
    skvt_pkg::cell_cmd_t              cmd;
    skvt_pkg::cell_pos_t              pos   [N];
    skvt_pkg::cell_link_t             link  [N+1];
    logic [skvt_pkg::KEY_W-1:0]       key_w [N];
    logic [skvt_pkg::VALUE_WIDTH-1:0] data_w[N];
    logic                             found;
    logic                             room;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign room = count_reg < skvt_pkg::COUNT_W'(N);

    assign cmd.we        = accept;
    assign cmd.func      = s_data.func;
    assign cmd.key       = s_data.key;
    assign cmd.value     = skvt_pkg::VALUE_WIDTH'(s_data.value_in);
    assign cmd.found_all = found;
    assign cmd.room      = room;

    assign link[0] = '0;
    assign found   = link[N].found;

    for (genvar i = 0; i < N; i++) begin : g_cell
        assign pos[i].in_range = skvt_pkg::COUNT_W'(i) < count_reg;
        assign pos[i].tail     = skvt_pkg::COUNT_W'(i) == count_reg;

        skvt_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .pos      (pos[i]),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .up_key   ((i == N - 1) ? key_w[i]  : key_w[(i + 1) % N]),
            .up_data  ((i == N - 1) ? data_w[i] : data_w[(i + 1) % N]),
            .key_o    (key_w[i]),
            .data_o   (data_w[i])
        );
    end

    always_comb begin
        count_next                = count_reg;
        m_data_next.hit           = found;
        m_data_next.value_out     = '0;
        m_data_next.full_error    = 1'b0;
        unique case (s_data.func)
            skvt_pkg::FN_GET: begin
                m_data_next.value_out = skvt_pkg::WORD_W'(link[N].value);
            end
            skvt_pkg::FN_ADD: begin
                if (!found) begin
                    if (room) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        m_data_next.full_error = 1'b1;
                    end
                end
            end
            skvt_pkg::FN_REMOVE: begin
                if (found) begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
        m_data_next.entry_count = skvt_pkg::ECOUNT_W'(count_next);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= skvt_pkg::COUNT_W'(N))
        else $error("entry count exceeds table size");

    a_full_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_error |-> !m_data.hit
            && m_data.entry_count == skvt_pkg::ECOUNT_W'(N))
        else $error("full_error with hit or table not full");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a transaction");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid && m_data.entry_count == skvt_pkg::ECOUNT_W'(count_reg))
        else $error("result missing or count mismatch");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the small key-value table.
// A driver feeds get, add and remove operations from a queue with random
// gaps. A shadow copy of the table computes each expected result, and a
// monitor with random stalls checks every result transaction field by field.
// Directed cases come first: empty table, extreme keys and values, replace,
// fill to capacity, add to a full table, and removes of the first slot, the
// last slot and a missing key. Random phases follow, with varied key pools
// and mixes of operations.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_OPS     = 50;
    localparam int POOL_MAX      = 40;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        skvt_pkg::in_t op;
        bit            drain;
    } queued_op_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    skvt_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    skvt_pkg::out_t m_data;

    queued_op_t     pending_ops[$];
    skvt_pkg::out_t pending_results[$];

    logic [skvt_pkg::KEY_W-1:0]       tbl_key [skvt_pkg::ENTRIES];
    logic [skvt_pkg::VALUE_WIDTH-1:0] tbl_val [skvt_pkg::ENTRIES];
    int                               tbl_count = 0;

    int             errors       = 0;
    int             quiet_cycles = 0;
    int             send_idle    = 0;
    int             send_burst   = 0;
    int             recv_hold    = 0;
    int             recv_pick    = 0;
    skvt_pkg::out_t want;

    small_key_value_table u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic skvt_pkg::out_t table_apply(skvt_pkg::in_t op);
        skvt_pkg::out_t res;
        int             slot;
        slot = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (slot < 0 && tbl_key[i] == op.key) begin
                slot = i;
            end
        end
        res     = '0;
        res.hit = (slot >= 0);
        case (op.func)
            skvt_pkg::FN_GET: begin
                if (slot >= 0) begin
                    res.value_out = skvt_pkg::WORD_W'(tbl_val[slot]);
                end
            end
            skvt_pkg::FN_ADD: begin
                if (slot >= 0) begin
                    tbl_val[slot] = skvt_pkg::VALUE_WIDTH'(op.value_in);
                end else if (tbl_count < skvt_pkg::ENTRIES) begin
                    tbl_key[tbl_count] = op.key;
                    tbl_val[tbl_count] = skvt_pkg::VALUE_WIDTH'(op.value_in);
                    tbl_count++;
                end else begin
                    res.full_error = 1'b1;
                end
            end
            skvt_pkg::FN_REMOVE: begin
                if (slot >= 0) begin
                    tbl_key[slot] = tbl_key[tbl_count-1];
                    tbl_val[slot] = tbl_val[tbl_count-1];
                    tbl_count--;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = skvt_pkg::ECOUNT_W'(tbl_count);
        return res;
    endfunction

    function automatic int draw_gap();
        int r;
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 20);
        send_burst = $urandom_range(20, 60);
        return 0;
    endfunction

    function automatic void report_mismatch(string field,
                                            logic [skvt_pkg::WORD_W-1:0] exp_val,
                                            logic [skvt_pkg::WORD_W-1:0] act_val);
        if (errors < MAX_REPORTS) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
        end
        errors++;
    endfunction

    task automatic push_op(logic [skvt_pkg::FUNC_W-1:0] f, logic [skvt_pkg::KEY_W-1:0] k,
                           logic [skvt_pkg::WORD_W-1:0] v, bit drain = 1'b0);
        queued_op_t q;
        q.op.func     = f;
        q.op.key      = k;
        q.op.value_in = v;
        q.drain       = drain;
        pending_ops.push_back(q);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_idle <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(table_apply(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    s_valid   <= 1'b0;
                    send_idle <= send_idle - 1;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].drain && pending_results.size() != 0)) begin
                    s_data    <= pending_ops[0].op;
                    s_valid   <= 1'b1;
                    send_idle <= draw_gap();
                    void'(pending_ops.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    if (errors < MAX_REPORTS) begin
                        $error("result transaction with no operation outstanding");
                    end
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.hit !== want.hit) begin
                        report_mismatch("hit", skvt_pkg::WORD_W'(want.hit),
                                        skvt_pkg::WORD_W'(m_data.hit));
                    end
                    if (m_data.value_out !== want.value_out) begin
                        report_mismatch("value_out", want.value_out, m_data.value_out);
                    end
                    if (m_data.full_error !== want.full_error) begin
                        report_mismatch("full_error", skvt_pkg::WORD_W'(want.full_error),
                                        skvt_pkg::WORD_W'(m_data.full_error));
                    end
                    if (m_data.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", skvt_pkg::WORD_W'(want.entry_count),
                                        skvt_pkg::WORD_W'(m_data.entry_count));
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
            end else begin
                recv_pick = $urandom_range(0, 99);
                if (recv_pick < 50) begin
                    m_ready   <= 1'b1;
                    recv_hold <= $urandom_range(0, 7);
                end else if (recv_pick < 85) begin
                    m_ready   <= 1'b0;
                    recv_hold <= $urandom_range(0, 2);
                end else if (recv_pick < 95) begin
                    m_ready   <= 1'b0;
                    recv_hold <= $urandom_range(3, 24);
                end else begin
                    m_ready   <= 1'b1;
                    recv_hold <= $urandom_range(40, 120);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        logic [skvt_pkg::KEY_W-1:0]  pool [POOL_MAX];
        int                          pool_n;
        int                          add_pct;
        int                          rem_pct;
        int                          pick;
        logic [skvt_pkg::FUNC_W-1:0] f;
        logic [skvt_pkg::KEY_W-1:0]  k;
        logic [skvt_pkg::WORD_W-1:0] v;

        push_op(skvt_pkg::FN_GET,    8'h00, 32'h0000_0000);
        push_op(skvt_pkg::FN_REMOVE, 8'h80, 32'hFFFF_FFFF);
        push_op(skvt_pkg::FN_ADD,    8'h00, 32'h0000_0000);
        push_op(skvt_pkg::FN_ADD,    8'hFF, 32'hFFFF_FFFF);
        push_op(skvt_pkg::FN_GET,    8'hFF, 32'h0000_0000);
        push_op(skvt_pkg::FN_ADD,    8'hFF, 32'hA5A5_5A5A);
        push_op(skvt_pkg::FN_GET,    8'hFF, 32'h0000_0000);
        push_op(skvt_pkg::FN_REMOVE, 8'h00, 32'h0000_0000);
        push_op(skvt_pkg::FN_GET,    8'h00, 32'h0000_0000);
        push_op(skvt_pkg::FN_REMOVE, 8'hFF, 32'h0000_0000);
        for (int i = 0; i < skvt_pkg::ENTRIES; i++) begin
            push_op(skvt_pkg::FN_ADD, {4'(i), ~4'(i)}, $urandom);
        end
        push_op(skvt_pkg::FN_ADD,    8'h00, 32'h1234_5678);
        push_op(skvt_pkg::FN_ADD,    8'h5A, 32'hFFFF_FFFF);
        push_op(skvt_pkg::FN_GET,    8'h5A, 32'h0000_0000);
        push_op(skvt_pkg::FN_REMOVE, 8'h0F, 32'h0000_0000);
        push_op(skvt_pkg::FN_REMOVE, 8'h00, 32'h0000_0000);
        push_op(skvt_pkg::FN_GET,    8'hF0, 32'h0000_0000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 5)
                0: pool_n = 4;
                1: pool_n = 20;
                2: pool_n = 12;
                3: pool_n = POOL_MAX;
                default: pool_n = 256;
            endcase
            add_pct = $urandom_range(20, 65);
            rem_pct = $urandom_range(10, 90 - add_pct);
            for (int i = 0; i < POOL_MAX; i++) begin
                pool[i] = skvt_pkg::KEY_W'($urandom_range(0, 255));
            end
            for (int i = 0; i < PHASE_OPS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct) begin
                    f = skvt_pkg::FN_ADD;
                end else if (pick < add_pct + rem_pct) begin
                    f = skvt_pkg::FN_REMOVE;
                end else begin
                    f = skvt_pkg::FN_GET;
                end
                if (pool_n > POOL_MAX || $urandom_range(0, 9) == 0) begin
                    k = skvt_pkg::KEY_W'($urandom_range(0, 255));
                end else begin
                    k = pool[$urandom_range(0, pool_n - 1)];
                end
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    v = '0;
                end else if (pick == 1) begin
                    v = '1;
                end else begin
                    v = $urandom;
                end
                push_op(f, k, v, i == 0 && (ph == 0 || $urandom_range(0, 1) == 1));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
